// ===== hdl/dqs_pkg.sv =====
// Shared types, codes and sizing for the bounded deque with search.
// No dependencies; imported by every module of the block.
package dqs_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_SEARCH     = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_POP_BACK   = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } dqs_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [4:0]         position;
    logic [5:0]         occupancy;
  } dqs_rsp_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_SHIFT_R,
    MODE_SHIFT_L,
    MODE_LOAD_BACK
  } dqs_mode_t;

  typedef struct packed {
    dqs_mode_t        mode;
    logic [IDX_W-1:0] back_idx;
  } dqs_cell_ctrl_t;

  function automatic logic [5:0] to_occ(input logic [CNT_W-1:0] cnt);
    to_occ = 6'(cnt);
  endfunction

endpackage

// ===== hdl/dqs_cell.sv =====
// One storage cell of the deque chain: holds one element and trades it
// with its neighbors. Depends on dqs_pkg.
module dqs_cell
  import dqs_pkg::*;
(
  input  logic               clk,
  input  logic [IDX_W-1:0]   idx,
  input  dqs_cell_ctrl_t     ctrl,
  input  logic signed [31:0] left,
  input  logic signed [31:0] right,
  input  logic signed [31:0] value,
  output logic signed [31:0] q
);

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      MODE_SHIFT_R: q <= left;
      MODE_SHIFT_L: q <= right;
      MODE_LOAD_BACK: begin
        if (idx == ctrl.back_idx) begin
          q <= value;
        end
      end
      default: q <= q;
    endcase
  end

endmodule

// ===== hdl/bounded_deque_with_search_core.sv =====
// Bounded double-ended queue of signed 32-bit values with search.
// Top level: control, element count and the chain of dqs_cell; uses dqs_pkg.
//
// Requests enter on req (valid/ready), one result per request leaves on rsp
// (valid/ready) through an output register. The front element always sits in
// cell 0; pushes and pops at the front shift the whole chain by one cell.
// Push, pop, clear and unused opcodes finish at the accepting edge: the result
// is valid the next cycle, one item per cycle while rsp is taken.
// A search on a non-empty queue rotates the chain through cell 0, comparing
// one element per cycle until the ring is back in place. One request is
// in flight at a time.
// req_ready is high when no search runs and the output register is free or
// being taken in the same cycle; a stalled rsp holds its result and blocks
// new requests.
// Reset empties the queue and clears rsp_valid; cell contents are not reset.
module bounded_deque_with_search_core
  import dqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dqs_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output dqs_rsp_t rsp
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   step;
  logic [IDX_W-1:0]   hit_pos;
  logic               found;
  logic signed [31:0] key;
  logic signed [31:0] cell_q [DEPTH];
  dqs_cell_ctrl_t     ctrl;
  logic               req_xfer;
  logic               rsp_load;
  dqs_rsp_t           rsp_next;
  logic               is_full, is_empty, hit, last_step;
  logic [IDX_W-1:0]   back_idx;

  assign req_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign req_xfer  = req_valid && req_ready;
  assign is_full   = (count == CNT_W'(DEPTH));
  assign is_empty  = (count == '0);
  assign back_idx  = IDX_W'(count - CNT_W'(1));
  assign last_step = (step == IDX_W'(DEPTH - 1));
  assign hit       = !found && (CNT_W'(step) < count) && (cell_q[0] == key);

  always_comb begin
    state_next    = state;
    count_next    = count;
    ctrl.mode     = MODE_HOLD;
    ctrl.back_idx = IDX_W'(count);
    rsp_load      = 1'b0;
    rsp_next      = '0;
    if (state == ST_SEARCH) begin
      ctrl.mode = MODE_SHIFT_L;
      if (last_step) begin
        state_next = ST_IDLE;
        rsp_load   = 1'b1;
        if (found || hit) begin
          rsp_next.status   = STATUS_OK;
          rsp_next.data     = key;
          rsp_next.position = 5'(found ? hit_pos : step);
        end else begin
          rsp_next.status = STATUS_NOT_FOUND;
        end
      end
    end else if (req_xfer) begin
      rsp_load = 1'b1;
      case (req.opcode)
        OP_SEARCH: begin
          if (is_empty) begin
            rsp_next.status = STATUS_EMPTY;
          end else begin
            rsp_load   = 1'b0;
            state_next = ST_SEARCH;
          end
        end
        OP_PUSH_FRONT: begin
          if (is_full) begin
            rsp_next.status = STATUS_FULL;
          end else begin
            ctrl.mode  = MODE_SHIFT_R;
            count_next = count + CNT_W'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (is_full) begin
            rsp_next.status = STATUS_FULL;
          end else begin
            ctrl.mode  = MODE_LOAD_BACK;
            count_next = count + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            rsp_next.status = STATUS_EMPTY;
          end else begin
            rsp_next.data = cell_q[0];
            ctrl.mode     = MODE_SHIFT_L;
            count_next    = count - CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            rsp_next.status = STATUS_EMPTY;
          end else begin
            rsp_next.data = cell_q[back_idx];
            count_next    = count - CNT_W'(1);
          end
        end
        OP_CLEAR: count_next = '0;
        default: ;
      endcase
    end
    rsp_next.occupancy = to_occ(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      found     <= 1'b0;
      step      <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == ST_SEARCH) begin
        step <= step + IDX_W'(1);
        if (hit) begin
          found <= 1'b1;
        end
      end else begin
        step  <= '0;
        found <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
    if (req_xfer) begin
      key <= req.value;
    end
    if (state == ST_SEARCH && hit) begin
      hit_pos <= step;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dqs_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .ctrl  (ctrl),
      .left  ((i == 0) ? req.value : cell_q[(i + DEPTH - 1) % DEPTH]),
      .right (cell_q[(i + 1) % DEPTH]),
      .value (req.value),
      .q     (cell_q[i])
    );
  end

endmodule

// ===== hdl/dqs_checker.sv =====
// Port-level checks for bounded_deque_with_search_core, attached by bind.
// Depends on dqs_pkg.
module dqs_port_checker
  import dqs_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input dqs_req_t req,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input dqs_rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_EMPTY |-> rsp.occupancy == '0 && rsp.data == '0)
    else $error("empty status with elements or data");

  a_full_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_FULL |-> rsp.data == '0 && rsp.position == '0
      && rsp.occupancy == to_occ(CNT_W'(DEPTH)))
    else $error("full status inconsistent");

  a_pos_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.position != '0 |-> rsp.status == STATUS_OK)
    else $error("position without successful search");

endmodule

bind bounded_deque_with_search_core dqs_port_checker u_dqs_port_checker (.*);

// ===== tb/sv/dqs_checker.sv =====
`timescale 1ns / 1ps
// Response checker for bounded_deque_with_search_core: mirrors the deque on each
// request transfer and compares each response transfer with the oldest prediction.
// Depends on dqs_pkg for the payload types, opcodes and status codes.
module dqs_checker
  import dqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  dqs_req_t    req,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  dqs_rsp_t    rsp,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  logic [31:0]      cells [DEPTH];
  logic [IDX_W-1:0] front;
  logic [CNT_W-1:0] held;
  dqs_rsp_t         owed_rsp_q [$];
  int unsigned      fails = 0;

  function automatic logic [IDX_W-1:0] slot_at(input int offset);
    return IDX_W'((int'(front) + offset) % DEPTH);
  endfunction

  function automatic dqs_rsp_t apply_request(input dqs_req_t r);
    dqs_rsp_t o;
    int       i;
    o = '0;
    case (r.opcode)
      OP_SEARCH: begin
        if (held == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.status = STATUS_NOT_FOUND;
          for (i = 0; i < int'(held); i++) begin
            if (cells[slot_at(i)] == r.value) begin
              o.status   = STATUS_OK;
              o.data     = r.value;
              o.position = 5'(i);
              break;
            end
          end
        end
      end
      OP_PUSH_FRONT: begin
        if (int'(held) >= DEPTH) begin
          o.status = STATUS_FULL;
        end else begin
          front = slot_at(DEPTH - 1);
          cells[front] = r.value;
          held = held + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (int'(held) >= DEPTH) begin
          o.status = STATUS_FULL;
        end else begin
          cells[slot_at(int'(held))] = r.value;
          held = held + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (held == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.data = cells[front];
          front = slot_at(1);
          held = held - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (held == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.data = cells[slot_at(int'(held) - 1)];
          held = held - 1'b1;
        end
      end
      OP_CLEAR: begin
        held  = '0;
        front = '0;
      end
      default: begin
      end
    endcase
    o.occupancy = 6'(held);
    return o;
  endfunction

  always @(posedge clk) begin : watch
    dqs_rsp_t want;
    if (rst) begin
      front = '0;
      held  = '0;
      owed_rsp_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (owed_rsp_q.size() == 0) begin
          $error("response transfer with no request outstanding");
          fails++;
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fails++;
          end
          if (rsp.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, rsp.data);
            fails++;
          end
          if (rsp.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp.position);
            fails++;
          end
          if (rsp.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, rsp.occupancy);
            fails++;
          end
        end
      end
      if (req_valid && req_ready) begin
        owed_rsp_q.push_back(apply_request(req));
      end
    end
    mismatches  <= fails;
    outstanding <= owed_rsp_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the bench for bounded_deque_with_search_core: clock, reset, request
// stimulus, response back-pressure and the verdict. Uses dqs_pkg and dqs_checker.
module testbench;
  import dqs_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 410;
  localparam int DRAIN_CYCLES    = 40;

  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_PROBE,
    BURST_MIX
  } burst_kind_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  dqs_req_t    req       = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  dqs_rsp_t    rsp;
  int unsigned mismatches;
  int unsigned outstanding;

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          sent          = 0;
  int unsigned cycle_count   = 0;
  logic [31:0] last_pushed   = '0;

  bounded_deque_with_search_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  dqs_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4, 5, 6: return 32'($urandom_range(6)) - 32'd3;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_op(input burst_kind_t kind);
    int roll;
    roll = $urandom_range(99);
    case (kind)
      BURST_FILL: begin
        if (roll < 40) return OP_PUSH_FRONT;
        if (roll < 80) return OP_PUSH_BACK;
        if (roll < 95) return OP_SEARCH;
      end
      BURST_DRAIN: begin
        if (roll < 40) return OP_POP_FRONT;
        if (roll < 80) return OP_POP_BACK;
        if (roll < 95) return OP_SEARCH;
      end
      BURST_PROBE: begin
        if (roll < 70) return OP_SEARCH;
        if (roll < 80) return OP_PUSH_BACK;
        if (roll < 90) return OP_POP_FRONT;
      end
      default: begin
      end
    endcase
    return 3'($urandom_range(7));
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{opcode: op, value: v};
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      last_pushed = v;
    end
    sent++;
  endtask

  initial begin
    burst_kind_t kind;
    int          burst_len;
    int          phase;
    int          k;
    logic [2:0]  op;
    logic [31:0] v;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send_item(OP_CLEAR, 32'h0);
    send_item(OP_SEARCH, 32'h0);
    send_item(OP_POP_FRONT, 32'h0);
    send_item(OP_POP_BACK, 32'h0);
    send_item(3'd6, 32'hffff_ffff);
    send_item(3'd7, 32'h0);
    send_item(OP_PUSH_BACK, 32'h7fff_ffff);
    send_item(OP_PUSH_FRONT, 32'h8000_0000);
    send_item(OP_PUSH_BACK, 32'h0);
    send_item(OP_PUSH_BACK, 32'hffff_ffff);
    send_item(OP_SEARCH, 32'h7fff_ffff);
    send_item(OP_SEARCH, 32'hffff_ffff);
    send_item(OP_SEARCH, 32'h0001_2345);
    send_item(OP_SEARCH, 32'h8000_0000);
    send_item(OP_POP_BACK, 32'h0);
    send_item(OP_POP_FRONT, 32'h0);
    send_item(OP_POP_FRONT, 32'h0);
    send_item(OP_POP_BACK, 32'h0);
    send_item(OP_SEARCH, 32'h0);
    send_item(OP_PUSH_FRONT, 32'h5);
    send_item(3'd6, 32'h0);
    send_item(OP_CLEAR, 32'h0);
    send_item(OP_POP_BACK, 32'h0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      while (sent < (phase + 1) * ITEMS_PER_PHASE) begin
        kind      = burst_kind_t'($urandom_range(3));
        burst_len = $urandom_range(45, 10);
        for (k = 0; k < burst_len; k++) begin
          op = pick_op(kind);
          v  = (op == OP_SEARCH && $urandom_range(3) == 0) ? last_pushed : pick_value();
          send_item(op, v);
        end
      end
    end
    req_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
